// ----- rtl/core/fee_pkg.sv -----
// ----------------------------------------------------------------------------
// fee_pkg
// Shared types, codes and constants for the feature entropy energy block.
// ----------------------------------------------------------------------------
package fee_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int KEY_W           = 32;
  localparam int HIT_W           = 16;
  localparam int ENTRY_W         = 9;
  localparam int ENERGY_W        = 32;
  localparam int GLOB_W          = 24;
  localparam int TIME_W          = 32;
  localparam int MUT_W           = 32;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 32;
  localparam int LOG_FRAC_W      = 24;
  localparam int MANT_W          = 32;
  localparam int SCORE_W         = 9;
  localparam int QUOT_W          = 64;

  localparam logic [31:0] LN2_Q32    = 32'hB17217F8;
  localparam logic [63:0] ENERGY_MAX = 64'h0000_0000_FFFF_FFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT  = 2'd1;

  localparam logic [1:0] CMD_COUNT  = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_ENERGY = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CHANGED  = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic [SCORE_W-1:0] SC_10  = 9'd10;
  localparam logic [SCORE_W-1:0] SC_25  = 9'd25;
  localparam logic [SCORE_W-1:0] SC_50  = 9'd50;
  localparam logic [SCORE_W-1:0] SC_75  = 9'd75;
  localparam logic [SCORE_W-1:0] SC_100 = 9'd100;
  localparam logic [SCORE_W-1:0] SC_150 = 9'd150;
  localparam logic [SCORE_W-1:0] SC_200 = 9'd200;
  localparam logic [SCORE_W-1:0] SC_300 = 9'd300;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [KEY_W-1:0]  feature_id;
    logic [GLOB_W-1:0] global_features;
    logic [MUT_W-1:0]  mutation_count;
    logic [TIME_W-1:0] average_time;
  } fee_req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [ENERGY_W-1:0] energy_value;
    logic [ENTRY_W-1:0]  entry_count;
  } fee_rsp_t;

  typedef enum logic [1:0] {
    LG_IDLE,
    LG_NORM,
    LG_ITER
  } fee_log_state_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SCAN,
    S_CMP,
    S_INS_RD,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_WR,
    S_E_RD,
    S_E_LOG,
    S_E_WAIT,
    S_E_A,
    S_E_AW,
    S_E_S,
    S_E_SW,
    S_E_D,
    S_E_DW,
    S_E_H,
    S_E_SC
  } fee_state_t;

endpackage

// ----- rtl/core/fee_ram.sv -----
// ----------------------------------------------------------------------------
// fee_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module fee_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/fee_log2.sv -----
// ----------------------------------------------------------------------------
// fee_log2
// Sequential fixed-point log2: shift-normalize one bit a cycle, then one
// squaring step per fraction bit.
// ----------------------------------------------------------------------------
module fee_log2
  import fee_pkg::*;
#(
  parameter int X_W    = 35,
  localparam int E_W   = $clog2(X_W),
  localparam int LOG_W = E_W + LOG_FRAC_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [X_W-1:0]   x,
  output logic             done,
  output logic [LOG_W-1:0] result
);

  fee_log_state_t state, state_next;
  logic [X_W-1:0]        xr;
  logic [E_W-1:0]        expo;
  logic [MANT_W-1:0]     mant;
  logic [LOG_FRAC_W-1:0] frac;
  logic [4:0]            step;
  logic [2*MANT_W-1:0]   sq_full;
  logic [MANT_W:0]       sq;

  assign sq_full = mant * mant;
  assign sq      = sq_full[2*MANT_W-1:MANT_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LG_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == LG_ITER) && (step == 5'(LOG_FRAC_W - 1));
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      LG_IDLE: if (start) state_next = LG_NORM;
      LG_NORM: if (xr[X_W-1] || (expo == '0)) state_next = LG_ITER;
      LG_ITER: if (step == 5'(LOG_FRAC_W - 1)) state_next = LG_IDLE;
      default: state_next = LG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      LG_IDLE: begin
        xr   <= x;
        expo <= E_W'(X_W - 1);
      end
      LG_NORM: begin
        if (xr[X_W-1] || (expo == '0)) begin
          mant <= xr[X_W-1 -: MANT_W];
          step <= '0;
        end else begin
          xr   <= {xr[X_W-2:0], 1'b0};
          expo <= expo - 1'b1;
        end
      end
      LG_ITER: begin
        frac <= {frac[LOG_FRAC_W-2:0], sq[MANT_W]};
        mant <= sq[MANT_W] ? sq[MANT_W:1] : sq[MANT_W-1:0];
        step <= step + 1'b1;
        if (step == 5'(LOG_FRAC_W - 1)) begin
          result <= {expo, frac[LOG_FRAC_W-2:0], sq[MANT_W]};
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/core/fee_div.sv -----
// ----------------------------------------------------------------------------
// fee_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fee_div #(
  parameter int N_W  = 64,
  parameter int D_W  = 35,
  localparam int C_W = $clog2(N_W)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [N_W-1:0] num,
  input  logic [D_W-1:0] den,
  output logic           done,
  output logic [N_W-1:0] quot
);

  logic           run;
  logic [C_W-1:0] cnt;
  logic [D_W-1:0] rem;
  logic [D_W-1:0] dr;
  logic [D_W:0]   trial;
  logic [D_W:0]   diff;

  assign trial = {rem, quot[N_W-1]};
  assign diff  = trial - {1'b0, dr};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= run && (cnt == '0);
      if (start) begin
        run <= 1'b1;
      end else if (cnt == '0) begin
        run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= num;
      dr   <= den;
      cnt  <= C_W'(N_W - 1);
    end else if (run) begin
      // keep the remainder when the trial subtraction borrows
      rem  <= diff[D_W] ? trial[D_W-1:0] : diff[D_W-1:0];
      quot <= {quot[N_W-2:0], ~diff[D_W]};
      cnt  <= cnt - 1'b1;
    end
  end

endmodule

// ----- rtl/core/feature_entropy_energy.sv -----
// ----------------------------------------------------------------------------
// feature_entropy_energy
// Sorted feature hit table in one RAM with count, delete and entropy energy.
// Count/delete: scan the sorted entries, then shift the entries behind the slot,
// each with a read and a write, all through the one RAM port. Energy: a serial
// log2 per entry, then the tail (two logs and a divider). An unused command
// finishes straight from idle.
// One item at a time, busy high while in work; done pulses one cycle and the
// receiver cannot stall. Synchronous reset empties the table; no clearing pass.
// ----------------------------------------------------------------------------
module feature_entropy_energy
  import fee_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  fee_req_t              request,
  output logic                  done,
  output fee_rsp_t              result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW     = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int ROW_W  = KEY_W + HIT_W;
  localparam int C_W    = HIT_W + 1;
  localparam int A_W    = MUT_W + 1;
  localparam int SUMC_W = CNT_W + C_W;
  localparam int S_W    = ((SUMC_W > A_W) ? SUMC_W : A_W) + 2;
  localparam int LOG_W  = $clog2(S_W) + LOG_FRAC_W;
  localparam int E1_W   = LOG_W - 8;
  localparam int T_W    = 64;

  fee_state_t state, state_next;
  fee_req_t   req;

  logic [CNT_W-1:0]    used, used_next;
  logic [CNT_W-1:0]    idx;
  logic [CNT_W-1:0]    j;
  logic                scale_by_time;
  logic [TIME_W-1:0]   unit_exec_time;
  logic [SUMC_W-1:0]   sumc;
  logic [T_W-1:0]      t_acc;
  logic [C_W-1:0]      c_reg;
  logic [S_W-1:0]      s_reg;
  logic [LOG_W-1:0]    ls_reg;
  logic [QUOT_W-1:0]   q_reg;
  logic [E1_W-1:0]     e1;
  logic [SCORE_W-1:0]  score;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [ROW_W-1:0]    ram_wdata, ram_rdata;
  logic [KEY_W-1:0]    row_key;
  logic [HIT_W-1:0]    row_hits;

  logic                log_start, log_done;
  logic [S_W-1:0]      log_x;
  logic [LOG_W-1:0]    log_res;
  logic                div_start, div_done;
  logic [QUOT_W-1:0]   div_quot;

  logic                fin;
  logic [1:0]          fin_status;
  logic [ENERGY_W-1:0] fin_energy;
  logic [A_W-1:0]      a_val;
  logic [C_W-1:0]      c_new;
  logic [LOG_W-1:0]    h;
  logic [LOG_W+31:0]   h_ln2;
  logic [E1_W+SCORE_W-1:0] scaled;
  logic [SCORE_W-1:0]  score_comb;
  logic [TIME_W+3:0]   u_x, v_x;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);
  assign row_key   = ram_rdata[ROW_W-1:HIT_W];
  assign row_hits  = ram_rdata[HIT_W-1:0];
  assign a_val     = A_W'(req.mutation_count) + 1'b1;
  assign c_new     = C_W'(row_hits) + 1'b1;
  assign h         = (QUOT_W'(ls_reg) > q_reg) ? (ls_reg - LOG_W'(q_reg)) : '0;
  assign h_ln2     = h * LN2_Q32;
  assign scaled    = e1 * score;

  // runtime score, first matching rule wins
  assign u_x = (TIME_W+4)'(unit_exec_time);
  assign v_x = (TIME_W+4)'(req.average_time);
  always_comb begin
    priority if (u_x > v_x * 10) score_comb = SC_10;
    else if (u_x > v_x * 4)      score_comb = SC_25;
    else if (u_x > v_x * 2)      score_comb = SC_50;
    else if (u_x * 3 > v_x * 4)  score_comb = SC_75;
    else if (u_x * 4 < v_x)      score_comb = SC_300;
    else if (u_x * 3 < v_x)      score_comb = SC_200;
    else if (u_x * 2 < v_x)      score_comb = SC_150;
    else                         score_comb = SC_100;
  end

  fee_ram #(.WIDTH(ROW_W), .DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fee_log2 #(.X_W(S_W)) u_log (
    .clk    (clk),
    .rst    (rst),
    .start  (log_start),
    .x      (log_x),
    .done   (log_done),
    .result (log_res)
  );

  fee_div #(.N_W(QUOT_W), .D_W(S_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (t_acc),
    .den   (s_reg),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    state_next = state;
    used_next  = used;
    ram_we     = 1'b0;
    ram_waddr  = idx[AW-1:0];
    ram_wdata  = {req.feature_id, HIT_W'(1)};
    ram_raddr  = idx[AW-1:0];
    log_start  = 1'b0;
    log_x      = S_W'(c_new);
    div_start  = 1'b0;
    fin        = 1'b0;
    fin_status = ST_OK;
    fin_energy = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          priority case (request.cmd)
            CMD_COUNT, CMD_DELETE: state_next = S_SCAN;
            CMD_ENERGY:            state_next = S_E_RD;
            default:               fin = 1'b1;
          endcase
        end
      end
      S_SCAN: begin
        if (idx == used) begin
          if (req.cmd == CMD_DELETE) begin
            fin        = 1'b1;
            fin_status = ST_NOTFOUND;
            state_next = S_IDLE;
          end else if (used == CNT_W'(TABLE_DEPTH)) begin
            fin        = 1'b1;
            fin_status = ST_FULL;
            state_next = S_IDLE;
          end else begin
            state_next = S_INS_RD;
          end
        end else begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (row_key < req.feature_id) begin
          state_next = S_SCAN;
        end else if (row_key == req.feature_id) begin
          if (req.cmd == CMD_DELETE) begin
            state_next = S_DEL_RD;
          end else begin
            // hit: bump the count in place, 16-bit wrap
            ram_we     = 1'b1;
            ram_wdata  = {req.feature_id, row_hits + 1'b1};
            fin        = 1'b1;
            state_next = S_IDLE;
          end
        end else if (req.cmd == CMD_DELETE) begin
          fin        = 1'b1;
          fin_status = ST_NOTFOUND;
          state_next = S_IDLE;
        end else if (used == CNT_W'(TABLE_DEPTH)) begin
          fin        = 1'b1;
          fin_status = ST_FULL;
          state_next = S_IDLE;
        end else begin
          state_next = S_INS_RD;
        end
      end
      S_INS_RD: begin
        if (j == idx) begin
          ram_we     = 1'b1;
          used_next  = used + 1'b1;
          fin        = 1'b1;
          fin_status = ST_CHANGED;
          state_next = S_IDLE;
        end else begin
          ram_raddr  = AW'(j - 1'b1);
          state_next = S_INS_WR;
        end
      end
      S_INS_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = j[AW-1:0];
        ram_wdata  = ram_rdata;
        state_next = S_INS_RD;
      end
      S_DEL_RD: begin
        if (j + 1'b1 == used) begin
          used_next  = used - 1'b1;
          fin        = 1'b1;
          fin_status = ST_CHANGED;
          state_next = S_IDLE;
        end else begin
          ram_raddr  = AW'(j + 1'b1);
          state_next = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = j[AW-1:0];
        ram_wdata  = ram_rdata;
        state_next = S_DEL_RD;
      end
      S_E_RD: begin
        state_next = (idx == used) ? S_E_A : S_E_LOG;
      end
      S_E_LOG: begin
        log_start  = 1'b1;
        state_next = S_E_WAIT;
      end
      S_E_WAIT: begin
        if (log_done) state_next = S_E_RD;
      end
      S_E_A: begin
        log_start  = 1'b1;
        log_x      = S_W'(a_val);
        state_next = S_E_AW;
      end
      S_E_AW: begin
        if (log_done) state_next = S_E_S;
      end
      S_E_S: begin
        log_start  = 1'b1;
        log_x      = s_reg;
        state_next = S_E_SW;
      end
      S_E_SW: begin
        if (log_done) state_next = S_E_D;
      end
      S_E_D: begin
        div_start  = 1'b1;
        state_next = S_E_DW;
      end
      S_E_DW: begin
        if (div_done) state_next = S_E_H;
      end
      S_E_H: begin
        state_next = S_E_SC;
      end
      S_E_SC: begin
        fin = 1'b1;
        if (scale_by_time) begin
          fin_energy = (64'(scaled) > ENERGY_MAX) ? ENERGY_MAX[ENERGY_W-1:0]
                                                  : ENERGY_W'(scaled);
        end else begin
          fin_energy = ENERGY_W'(e1);
        end
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      used           <= '0;
      done           <= 1'b0;
      scale_by_time  <= 1'b0;
      unit_exec_time <= '0;
    end else begin
      state <= state_next;
      used  <= used_next;
      done  <= fin;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_SCALE) scale_by_time <= cfg_data[0];
        if (cfg_index == CFG_UNIT)  unit_exec_time <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      result.status       <= fin_status;
      result.energy_value <= fin_energy;
      result.entry_count  <= ENTRY_W'(used_next);
    end
    unique case (state)
      S_IDLE: begin
        req   <= request;
        idx   <= '0;
        sumc  <= '0;
        t_acc <= '0;
      end
      S_CMP: begin
        if (row_key < req.feature_id) idx <= idx + 1'b1;
        // insert shifts from the top down, delete from the hole up
        j <= (req.cmd == CMD_DELETE) ? idx : used;
      end
      S_SCAN:   j <= used;
      S_INS_WR: j <= j - 1'b1;
      S_DEL_WR: j <= j + 1'b1;
      S_E_LOG: begin
        c_reg <= c_new;
        sumc  <= sumc + SUMC_W'(c_new);
      end
      S_E_WAIT: begin
        if (log_done) begin
          t_acc <= t_acc + T_W'(c_reg * log_res);
          idx   <= idx + 1'b1;
        end
      end
      S_E_A: begin
        s_reg <= S_W'(sumc) + S_W'(req.global_features) + S_W'(a_val) - S_W'(used);
      end
      S_E_AW: begin
        if (log_done) t_acc <= t_acc + T_W'(a_val * log_res);
      end
      S_E_SW: begin
        if (log_done) ls_reg <= log_res;
      end
      S_E_DW: begin
        if (div_done) q_reg <= div_quot;
      end
      S_E_H: begin
        e1    <= h_ln2[LOG_W+31:40];
        score <= score_comb;
      end
      default: ;
    endcase
  end

endmodule

// ----- dv/feature_entropy_energy_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feature_entropy_energy_tb
// Drives count, delete and energy commands into the feature table, predicts
// every response word with a behavioral table and fixed-point entropy math,
// and compares status, energy and entry count in order of arrival.
// ----------------------------------------------------------------------------
module feature_entropy_energy_tb;
  import fee_pkg::*;

  localparam int DEPTH     = TABLE_DEPTH_DEF;
  localparam int CYC_LIMIT = 40000000;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  logic            clk;
  logic            rst;
  logic            start;
  logic            busy;
  fee_req_t        request;
  logic            done;
  fee_rsp_t        result;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  feature_entropy_energy uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predicted table state
  logic [31:0] tbl_keys [DEPTH];
  logic [15:0] tbl_hits [DEPTH];
  int          tbl_used;
  logic        scale_on;
  logic [31:0] unit_time;

  fee_rsp_t rsp_pending[$];
  int       mismatches;
  int       cycles;
  int       idle_pct;

  logic [31:0] u_list [4] = '{32'd0, 32'd1000, 32'd77777, 32'hFFFF_FFFF};

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [63:0] log2_fix(input logic [63:0] x);
    int          e;
    logic [63:0] m;
    logic [63:0] fr;
    e = 63;
    fr = 0;
    if (x == 0) return 0;
    while (x[e] == 1'b0) e--;
    if (e >= 31) m = x >> (e - 31);
    else m = x << (31 - e);
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 31;
      fr = fr << 1;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        fr[0] = 1'b1;
      end
    end
    return (64'(e) << 24) | fr;
  endfunction

  function automatic logic [SCORE_W-1:0] time_score(input logic [63:0] u,
                                                    input logic [63:0] v);
    if (u > v * 10) return SC_10;
    if (u > v * 4) return SC_25;
    if (u > v * 2) return SC_50;
    if (u * 3 > v * 4) return SC_75;
    if (u * 4 < v) return SC_300;
    if (u * 3 < v) return SC_200;
    if (u * 2 < v) return SC_150;
    return SC_100;
  endfunction

  function automatic logic [31:0] entropy_energy(input fee_req_t rq);
    logic [63:0] s, t, c, a, ls, q, h, e;
    s = 0;
    t = 0;
    for (int i = 0; i < tbl_used; i++) begin
      c = 64'(tbl_hits[i]) + 1;
      s += c;
      t += c * log2_fix(c);
    end
    s = s + 64'(rq.global_features) - 64'(tbl_used);
    a = 64'(rq.mutation_count) + 1;
    s += a;
    t += a * log2_fix(a);
    if (s == 0) return 0;
    ls = log2_fix(s);
    q = t / s;
    h = (ls > q) ? ls - q : 64'd0;
    e = (h * 64'(LN2_Q32)) >> 40;
    if (scale_on) begin
      e = e * 64'(time_score(64'(unit_time), 64'(rq.average_time)));
      if (e > ENERGY_MAX) e = ENERGY_MAX;
    end
    return e[31:0];
  endfunction

  function automatic fee_rsp_t table_update(input fee_req_t rq);
    fee_rsp_t r;
    int       pos;
    r = '0;
    pos = 0;
    if (rq.cmd == CMD_COUNT || rq.cmd == CMD_DELETE)
      while (pos < tbl_used && tbl_keys[pos] < rq.feature_id) pos++;
    if (rq.cmd == CMD_COUNT) begin
      if (pos < tbl_used && tbl_keys[pos] == rq.feature_id) begin
        tbl_hits[pos] = tbl_hits[pos] + 16'd1;
        r.status = ST_OK;
      end else if (tbl_used >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        for (int j = tbl_used; j > pos; j--) begin
          tbl_keys[j] = tbl_keys[j-1];
          tbl_hits[j] = tbl_hits[j-1];
        end
        tbl_keys[pos] = rq.feature_id;
        tbl_hits[pos] = 16'd1;
        tbl_used++;
        r.status = ST_CHANGED;
      end
    end else if (rq.cmd == CMD_DELETE) begin
      if (pos < tbl_used && tbl_keys[pos] == rq.feature_id) begin
        for (int j = pos; j + 1 < tbl_used; j++) begin
          tbl_keys[j] = tbl_keys[j+1];
          tbl_hits[j] = tbl_hits[j+1];
        end
        tbl_used--;
        r.status = ST_CHANGED;
      end else begin
        r.status = ST_NOTFOUND;
      end
    end else if (rq.cmd == CMD_ENERGY) begin
      r.energy_value = entropy_energy(rq);
      r.status = ST_OK;
    end
    r.entry_count = ENTRY_W'(tbl_used);
    return r;
  endfunction

  // compare each response word with the oldest prediction
  always @(posedge clk) begin
    fee_rsp_t want;
    if (!rst && done) begin
      if (rsp_pending.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected response %h", result);
      end else begin
        want = rsp_pending.pop_front();
        if (want !== result) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: status %0d/%0d energy %h/%h entries %0d/%0d",
                     want.status, result.status, want.energy_value,
                     result.energy_value, want.entry_count, result.entry_count);
        end
      end
    end
  end

  task automatic send_word(input fee_req_t rq);
    fee_rsp_t exp_rsp;
    while ($urandom_range(99, 0) < idle_pct) @(posedge clk);
    start <= 1'b1;
    request <= rq;
    @(posedge clk);
    // hold the word until the block is no longer busy
    while (busy) @(posedge clk);
    exp_rsp = table_update(rq);
    rsp_pending = {rsp_pending, exp_rsp};
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain;
    while (rsp_pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_SCALE) scale_on = val[0];
    else unit_time = val;
  endtask

  function automatic fee_req_t make_req(input logic [1:0] c, input logic [31:0] id);
    fee_req_t rq;
    rq.cmd = c;
    rq.feature_id = id;
    rq.global_features = GLOB_W'($urandom);
    rq.mutation_count = $urandom;
    rq.average_time = $urandom;
    return rq;
  endfunction

  function automatic logic [31:0] rand_id;
    int k;
    k = $urandom_range(9, 0);
    if (k < 6) return $urandom_range(40, 0);
    if (k < 8) return 32'hFFFF_FFFF - $urandom_range(8, 0);
    return $urandom;
  endfunction

  task automatic test_directed;
    fee_req_t rq;
    send_word(make_req(CMD_DELETE, 32'd5));
    rq = make_req(CMD_ENERGY, 32'd0);
    rq.global_features = '0;
    rq.mutation_count = '0;
    send_word(rq);
    send_word(make_req(CMD_COUNT, 32'hFFFF_FFFF));
    send_word(make_req(CMD_COUNT, 32'h0));
    send_word(make_req(CMD_COUNT, 32'h8000_0000));
    send_word(make_req(CMD_COUNT, 32'h0));
    send_word(make_req(CMD_DELETE, 32'h1234));
    send_word(make_req(CMD_DELETE, 32'h8000_0000));
    rq = make_req(CMD_ENERGY, 32'd0);
    rq.global_features = '1;
    rq.mutation_count = '1;
    rq.average_time = '1;
    send_word(rq);
    rq.global_features = '0;
    rq.mutation_count = 32'd3;
    send_word(rq);
    send_word(make_req(CMD_SPARE, $urandom));
  endtask

  task automatic test_full_table;
    for (int i = 0; tbl_used < DEPTH; i++) send_word(make_req(CMD_COUNT, 32'(i * 7 + 100)));
    send_word(make_req(CMD_COUNT, 32'h7777_7777));
    send_word(make_req(CMD_COUNT, 32'd100));
    send_word(make_req(CMD_ENERGY, 32'd0));
    while (tbl_used > 200)
      send_word(make_req(CMD_DELETE, tbl_keys[$urandom_range(tbl_used - 1, 0)]));
  endtask

  task automatic test_random(input int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99, 0);
      if (k < 50) send_word(make_req(CMD_COUNT, rand_id()));
      else if (k < 70 && tbl_used > 0)
        send_word(make_req(CMD_DELETE, tbl_keys[$urandom_range(tbl_used - 1, 0)]));
      else if (k < 75) send_word(make_req(CMD_DELETE, rand_id()));
      else if (k < 97) begin
        fee_req_t rq;
        rq = make_req(CMD_ENERGY, 32'd0);
        if ($urandom_range(1, 0)) begin
          rq.average_time = $urandom_range(3000, 0);
          rq.mutation_count = $urandom_range(5000, 0);
          rq.global_features = GLOB_W'($urandom_range(500, 0));
        end
        send_word(rq);
      end else send_word(make_req(CMD_SPARE, $urandom));
    end
  endtask

  task automatic test_time_score;
    write_reg(CFG_SCALE, 32'd1);
    foreach (u_list[i]) begin
      write_reg(CFG_UNIT, u_list[i]);
      for (int d = 0; d < 10; d++) begin
        fee_req_t rq;
        rq = make_req(CMD_ENERGY, 32'd0);
        rq.average_time = (d < 8) ? (u_list[i] * 10 / (d + 1)) + $urandom_range(2, 0)
                                 : $urandom;
        send_word(rq);
      end
    end
  endtask

  initial begin
    cycles = 0;
    mismatches = 0;
    idle_pct = 0;
    start = 1'b0;
    request = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    tbl_used = 0;
    scale_on = 1'b0;
    unit_time = '0;
    rst = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_full_table();
    test_random(60);
    idle_pct = 71;
    test_time_score();
    write_reg(CFG_UNIT, 32'd500);
    test_random(50);
    idle_pct = 15;
    write_reg(CFG_SCALE, 32'd0);
    test_random(50);
    idle_pct = 0;
    write_reg(CFG_SCALE, 32'd1);
    test_random(56);
    drain();
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- feature_entropy_energy.f -----
rtl/core/fee_pkg.sv
rtl/core/fee_ram.sv
rtl/core/fee_log2.sv
rtl/core/fee_div.sv
rtl/core/feature_entropy_energy.sv
dv/feature_entropy_energy_tb.sv
